// File: hw/rtl/grid_line_of_sight_check_assert.svh
// ----------------------------------------------------------------------------
// Line of sight check assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_CHECK_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define GLOS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("line of sight check assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line of sight check assertion failed");
`else
`define GLOS_ASSERT(label, clk, rst_n, prop)
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/glos_pkg.sv
// ----------------------------------------------------------------------------
// Line of sight check package
// Shared types, codes and constants of the controller and the datapath.
// ----------------------------------------------------------------------------
package glos_pkg;

    // Width of an input cell coordinate.
    localparam int IN_W  = 6;
    // Signed walk coordinate: the side cell may fall one past the grid.
    localparam int POS_W = 8;
    // Signed Bresenham error term.
    localparam int ERR_W = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [ERR_W-1:0] t_err;

    localparam t_pos POS_PLUS  = 8'sd1;
    localparam t_pos POS_MINUS = -8'sd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAIN,
        ST_SIDE,
        ST_LAST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic map_wr;
        logic load;
        logic rd_main;
        logic rd_side;
        logic step;
        logic out_load;
        logic out_vis;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic rd_blocked;
        logic err_nz;
        logic cnt_zero;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/glos_datapath.sv
// ----------------------------------------------------------------------------
// Line of sight check datapath
// Obstruction map, Bresenham walk registers and the result word register.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_check_assert.svh"

module glos_datapath #(
    parameter int GRID_SIDE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  glos_pkg::t_cmd              i_cmd,
    output glos_pkg::t_status           o_status,
    input  logic [glos_pkg::IN_W-1:0]   i_start_x,
    input  logic [glos_pkg::IN_W-1:0]   i_start_y,
    input  logic [glos_pkg::IN_W-1:0]   i_end_x,
    input  logic [glos_pkg::IN_W-1:0]   i_end_y,
    input  logic                        i_cell_blocked,
    output logic                        o_valid,
    output logic                        o_visible,
    input  logic                        i_ready
);
    import glos_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_SIDE);

    function automatic logic f_in_grid(input t_pos p);
        return !p[POS_W-1] && (int'(p) < GRID_SIDE);
    endfunction

    function automatic logic [AW-1:0] f_index(input t_pos px, input t_pos py);
        return AW'(XW'(unsigned'(py))) * AW'(GRID_SIDE) + AW'(XW'(unsigned'(px)));
    endfunction

    // Map storage and clearing sweep
    logic              r_map [CELLS];
    logic [AW-1:0]     r_clr_addr;
    logic              r_rd_blocked;

    // Walk state
    t_pos              r_x, r_y;
    t_err              r_err;
    logic [IN_W-1:0]   r_dmaj, r_dmin, r_cnt;
    logic              r_sx_neg, r_sy_neg, r_major_x;

    // Result word
    logic              r_out_valid, r_visible;

    // Setup
    logic              swap;
    logic [IN_W-1:0]   ax, ay, bx, by, adx, ady;
    logic signed [IN_W:0] ddx, ddy;
    logic              major_x;

    // Step and side cell
    t_err              err_sum, err_next;
    logic              minor_step;
    t_pos              sx_d, sy_d, x_next, y_next, side_d, side_x, side_y;
    logic              side_neg;

    // Map access
    t_pos              rd_x, rd_y, wr_x, wr_y;
    logic              rd_en, rd_ok, wr_ok, map_we, map_wdata;
    logic [AW-1:0]     rd_addr, map_waddr;

    // Order the endpoints so the walk starts at the larger x, then larger y.
    always_comb begin
        swap    = (i_end_x > i_start_x) || ((i_end_x == i_start_x) && (i_end_y > i_start_y));
        ax      = swap ? i_end_x   : i_start_x;
        ay      = swap ? i_end_y   : i_start_y;
        bx      = swap ? i_start_x : i_end_x;
        by      = swap ? i_start_y : i_end_y;
        ddx     = signed'({1'b0, bx}) - signed'({1'b0, ax});
        ddy     = signed'({1'b0, by}) - signed'({1'b0, ay});
        adx     = ddx[IN_W] ? IN_W'(-ddx) : ddx[IN_W-1:0];
        ady     = ddy[IN_W] ? IN_W'(-ddy) : ddy[IN_W-1:0];
        major_x = adx > ady;
    end

    // One Bresenham step along the major axis.
    always_comb begin
        sx_d       = r_sx_neg ? POS_MINUS : POS_PLUS;
        sy_d       = r_sy_neg ? POS_MINUS : POS_PLUS;
        err_sum    = r_err + signed'(ERR_W'(r_dmin));
        minor_step = signed'({err_sum, 1'b0}) >= signed'((ERR_W+1)'(r_dmaj));
        err_next   = minor_step ? err_sum - signed'(ERR_W'(r_dmaj)) : err_sum;
        if (r_major_x) begin
            x_next = r_x + sx_d;
            y_next = minor_step ? r_y + sy_d : r_y;
        end else begin
            x_next = minor_step ? r_x + sx_d : r_x;
            y_next = r_y + sy_d;
        end
    end

    // Side cell lies across the major axis, toward the sign of the error.
    always_comb begin
        side_neg = r_err[ERR_W-1] ^ (r_major_x ? r_sy_neg : r_sx_neg);
        side_d   = side_neg ? POS_MINUS : POS_PLUS;
        side_x   = r_major_x ? r_x : r_x + side_d;
        side_y   = r_major_x ? r_y + side_d : r_y;
    end

    always_comb begin
        rd_en     = i_cmd.rd_main | i_cmd.rd_side;
        rd_x      = i_cmd.rd_side ? side_x : r_x;
        rd_y      = i_cmd.rd_side ? side_y : r_y;
        rd_ok     = f_in_grid(rd_x) && f_in_grid(rd_y);
        rd_addr   = rd_ok ? f_index(rd_x, rd_y) : '0;
        wr_x      = POS_W'(i_start_x);
        wr_y      = POS_W'(i_start_y);
        wr_ok     = f_in_grid(wr_x) && f_in_grid(wr_y);
        map_we    = i_cmd.clr_step | (i_cmd.map_wr & wr_ok);
        map_waddr = i_cmd.clr_step ? r_clr_addr : (wr_ok ? f_index(wr_x, wr_y) : '0);
        map_wdata = i_cmd.clr_step ? 1'b0 : i_cell_blocked;
    end

    // Off-grid cells read as clear.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        if (rd_en) begin
            r_rd_blocked <= rd_ok ? r_map[rd_addr] : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x       <= POS_W'(ax);
            r_y       <= POS_W'(ay);
            r_err     <= '0;
            r_dmaj    <= major_x ? adx : ady;
            r_dmin    <= major_x ? ady : adx;
            r_cnt     <= major_x ? adx : ady;
            r_sx_neg  <= ddx[IN_W];
            r_sy_neg  <= ddy[IN_W];
            r_major_x <= major_x;
        end else if (i_cmd.step) begin
            r_x   <= x_next;
            r_y   <= y_next;
            r_err <= err_next;
            r_cnt <= IN_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_visible <= i_cmd.out_vis;
        end
    end

    always_comb begin
        o_status.clr_last   = r_clr_addr == AW'(CELLS - 1);
        o_status.rd_blocked = r_rd_blocked;
        o_status.err_nz     = r_err != '0;
        o_status.cnt_zero   = r_cnt == '0;
        o_status.out_free   = !r_out_valid || i_ready;
    end

    assign o_valid   = r_out_valid;
    assign o_visible = r_visible;

    `GLOS_ASSERT(a_step_cnt, i_clk, i_rst_n, !i_cmd.step || (r_cnt != '0))
    `GLOS_ASSERT(a_side_err, i_clk, i_rst_n, !i_cmd.rd_side || (r_err != '0))
    `GLOS_ASSERT(a_wr_rd_excl, i_clk, i_rst_n, !(map_we && rd_en))

endmodule

// File: hw/rtl/glos_ctrl.sv
// ----------------------------------------------------------------------------
// Line of sight check controller
// Sequences map clearing, cell writes and the line walk of up to two reads per step.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_check_assert.svh"

module glos_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  glos_pkg::t_status i_status,
    output glos_pkg::t_cmd    o_cmd
);
    import glos_pkg::*;

    t_state r_state, n_state;
    logic   r_side_pend, n_side_pend;
    logic   r_vis, n_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_side_pend <= 1'b0;
            r_vis       <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_side_pend <= n_side_pend;
            r_vis       <= n_vis;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_side_pend = r_side_pend;
        n_vis       = r_vis;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid && (i_op == OP_QUERY)) begin
                    n_state     = ST_MAIN;
                    n_side_pend = 1'b0;
                    n_vis       = 1'b1;
                end
            end
            ST_MAIN: begin
                // Check the side cell of the previous step.
                if (r_side_pend && i_status.rd_blocked) begin
                    n_vis   = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SIDE;
                end
            end
            ST_SIDE: begin
                if (i_status.rd_blocked) begin
                    n_vis   = 1'b0;
                    n_state = ST_DONE;
                end else begin
                    n_side_pend = i_status.err_nz;
                    if (!i_status.cnt_zero) begin
                        n_state = ST_MAIN;
                    end else if (i_status.err_nz) begin
                        n_state = ST_LAST;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_LAST: begin
                if (i_status.rd_blocked) begin
                    n_vis = 1'b0;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_vis = r_vis;
        o_ready       = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.load   = i_valid && (i_op == OP_QUERY);
                o_cmd.map_wr = i_valid && (i_op == OP_WRITE);
            end
            ST_MAIN: begin
                o_cmd.rd_main = 1'b1;
            end
            ST_SIDE: begin
                if (!i_status.rd_blocked) begin
                    o_cmd.rd_side = i_status.err_nz;
                    o_cmd.step    = !i_status.cnt_zero;
                end
            end
            ST_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    `GLOS_ASSERT_NEXT(a_no_reclear, i_clk, i_rst_n, r_state != ST_CLEAR, r_state != ST_CLEAR)
    `GLOS_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, o_cmd.out_load, r_state == ST_IDLE)
    `GLOS_ASSERT_NEXT(a_last_side, i_clk, i_rst_n, n_state == ST_LAST, $past(r_state) != ST_LAST)

endmodule

// File: hw/rtl/grid_line_of_sight_check.sv
// ----------------------------------------------------------------------------
// Grid line of sight check
// Occupancy map of GRID_SIDE x GRID_SIDE cells with a Bresenham visibility
// query between two cells.
// ----------------------------------------------------------------------------
// After reset the block clears the whole map, one cell per cycle; o_ready stays
// low until then. A write word (op 0) sets or clears one cell; a write outside
// the grid is dropped. A query word (op 1) walks the line from the cell with
// the larger x (larger y on a tie) and returns one result word: visible 0 on
// the first obstructed cell tested, 1 otherwise. Cells off the grid read as
// clear. A query stops early on an obstructed cell. The single map read port
// serves the stepped cell and the side cell of each step in turn, in the MAIN
// and SIDE states. The block handles one word at a time; the result register
// lets the next word be accepted while a result still waits on the output
// channel.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check #(
    parameter int GRID_SIDE = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic [glos_pkg::IN_W-1:0] i_start_x,
    input  logic [glos_pkg::IN_W-1:0] i_start_y,
    input  logic [glos_pkg::IN_W-1:0] i_end_x,
    input  logic [glos_pkg::IN_W-1:0] i_end_y,
    input  logic                      i_cell_blocked,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_visible
);
    import glos_pkg::*;

    // Command and status between controller and datapath
    t_cmd    cmd;
    t_status status;

    // Sequence clear, write and walk steps.
    glos_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Hold the map, the walk registers and the result word.
    glos_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_cell_blocked (i_cell_blocked),
        .o_valid        (o_valid),
        .o_visible      (o_visible),
        .i_ready        (i_ready)
    );

endmodule
